[hw/rtl/f16rds_pkg.sv]
// Shared types and constants of the FAT16 root directory search block.
package f16rds_pkg;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_END       = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SEARCH_MODE  = 2'd0,
    CFG_TARGET_NAME  = 2'd1,
    CFG_TARGET_EXT   = 2'd2,
    CFG_TARGET_INDEX = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned NAME_W     = 64;
  localparam int unsigned EXT_W      = 24;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned CLUSTER_W  = 16;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned COUNT_W    = 16;

  localparam logic [7:0] LEAD_END     = 8'h00;
  localparam logic [7:0] LEAD_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;
  localparam logic [7:0] ATTR_DIR     = 8'h10;

  localparam logic [NAME_W-1:0]  NAME_RESET  = 64'h2020_2020_2020_2020;
  localparam logic [EXT_W-1:0]   EXT_RESET   = 24'h20_2020;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

endpackage

[hw/rtl/f16rds_if.sv]
// Valid/ready channel interfaces for directory entries and search results.
interface f16rds_in_if;
  logic        valid;
  logic        ready;
  logic        first_entry;
  logic        last_entry;
  logic [63:0] entry_name;
  logic [23:0] entry_ext;
  logic [7:0]  entry_attr;
  logic [15:0] entry_cluster;
  logic [31:0] entry_size;

  modport source (
    output valid, first_entry, last_entry, entry_name, entry_ext, entry_attr,
           entry_cluster, entry_size,
    input  ready
  );
  modport sink (
    input  valid, first_entry, last_entry, entry_name, entry_ext, entry_attr,
           entry_cluster, entry_size,
    output ready
  );
endinterface

interface f16rds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_cluster;
  logic [31:0] found_size;
  logic        is_directory;
  logic [63:0] found_name;
  logic [23:0] found_ext;

  modport source (
    output valid, status, found_cluster, found_size, is_directory, found_name,
           found_ext,
    input  ready
  );
  modport sink (
    input  valid, status, found_cluster, found_size, is_directory, found_name,
           found_ext,
    output ready
  );
endinterface

[hw/rtl/fat16_root_directory_search_top.sv]
// FAT16 root directory search: entries in, at most one found/end/exhausted word per search.
// Takes one 144-bit entry word per cycle while the entry register is empty or draining. Each
// entry is registered, classified and compared against the target name or index in one pass;
// any result enters the output register as it advances, which also frees the entry register,
// so a stalled result holds at most one more entry. A word with first_entry set starts a new
// search; after a result, later entries yield nothing until then. Configuration registers
// are written via cfg_*; the user must do so only while no search is in flight (unenforced).
module fat16_root_directory_search_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [f16rds_pkg::CFG_DATA_W-1:0] cfg_data,
  f16rds_in_if.sink                       in_ch,
  f16rds_out_if.source                    out_ch
);
  import f16rds_pkg::*;

  logic                 search_mode_r;
  logic [NAME_W-1:0]    target_name_r;
  logic [EXT_W-1:0]     target_ext_r;
  logic [COUNT_W-1:0]   target_index_r;

  logic [COUNT_W-1:0]   valid_count_r, valid_count_nxt;
  logic                 search_done_r, search_done_nxt;

  logic                 s1_valid_r;
  logic                 s1_first_r;
  logic                 s1_last_r;
  logic [NAME_W-1:0]    s1_name_r;
  logic [EXT_W-1:0]     s1_ext_r;
  logic [ATTR_W-1:0]    s1_attr_r;
  logic [CLUSTER_W-1:0] s1_cluster_r;
  logic [SIZE_W-1:0]    s1_size_r;

  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [CLUSTER_W-1:0] cluster_r, cluster_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic                 is_dir_r, is_dir_nxt;
  logic [NAME_W-1:0]    name_r, name_nxt;
  logic [EXT_W-1:0]     ext_r, ext_nxt;

  logic                 adv;
  logic                 in_fire;
  logic                 s1_fire;
  logic                 res_valid;
  logic [COUNT_W-1:0]   count_eff;
  logic                 done_eff;
  logic [7:0]           lead;
  logic                 entry_ok;
  logic                 hit;

  assign adv     = !out_valid_r || out_ch.ready;
  assign s1_fire = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_mode_r  <= 1'b0;
      target_name_r  <= NAME_RESET;
      target_ext_r   <= EXT_RESET;
      target_index_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEARCH_MODE:  search_mode_r  <= cfg_data[0];
        CFG_TARGET_NAME:  target_name_r  <= cfg_data[NAME_W-1:0];
        CFG_TARGET_EXT:   target_ext_r   <= cfg_data[EXT_W-1:0];
        CFG_TARGET_INDEX: target_index_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire || (s1_valid_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first_r   <= in_ch.first_entry;
      s1_last_r    <= in_ch.last_entry;
      s1_name_r    <= in_ch.entry_name;
      s1_ext_r     <= in_ch.entry_ext;
      s1_attr_r    <= in_ch.entry_attr;
      s1_cluster_r <= in_ch.entry_cluster;
      s1_size_r    <= in_ch.entry_size;
    end
  end

  always_comb begin
    count_eff = s1_first_r ? '0 : valid_count_r;
    done_eff  = s1_first_r ? 1'b0 : search_done_r;
    lead      = s1_name_r[NAME_W-1 -: 8];
    entry_ok  = !(lead == LEAD_DELETED || s1_attr_r == ATTR_LFN ||
                  (s1_attr_r & ATTR_VOLUME) != '0);
    hit       = search_mode_r ? (count_eff == target_index_r)
                              : (s1_name_r == target_name_r && s1_ext_r == target_ext_r);

    valid_count_nxt = count_eff;
    search_done_nxt = done_eff;
    res_valid       = 1'b0;
    status_nxt      = ST_EXHAUSTED;
    cluster_nxt     = '0;
    size_nxt        = '0;
    is_dir_nxt      = 1'b0;
    name_nxt        = '0;
    ext_nxt         = '0;

    if (!done_eff) begin
      if (lead == LEAD_END) begin
        search_done_nxt = 1'b1;
        res_valid       = 1'b1;
        status_nxt      = ST_END;
      end else if (entry_ok && hit) begin
        search_done_nxt = 1'b1;
        res_valid       = 1'b1;
        status_nxt      = ST_FOUND;
        cluster_nxt     = s1_cluster_r;
        size_nxt        = s1_size_r;
        is_dir_nxt      = (s1_attr_r & ATTR_DIR) != '0;
        name_nxt        = s1_name_r;
        ext_nxt         = s1_ext_r;
      end else begin
        if (entry_ok && count_eff != COUNT_MAX) begin
          valid_count_nxt = count_eff + 1'b1;
        end
        if (s1_last_r) begin
          search_done_nxt = 1'b1;
          res_valid       = 1'b1;
          status_nxt      = ST_EXHAUSTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_count_r <= '0;
      search_done_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (s1_fire) begin
        valid_count_r <= valid_count_nxt;
        search_done_r <= search_done_nxt;
      end
      if (adv) begin
        out_valid_r <= s1_fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      status_r  <= status_nxt;
      cluster_r <= cluster_nxt;
      size_r    <= size_nxt;
      is_dir_r  <= is_dir_nxt;
      name_r    <= name_nxt;
      ext_r     <= ext_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.found_cluster = cluster_r;
  assign out_ch.found_size    = size_r;
  assign out_ch.is_directory  = is_dir_r;
  assign out_ch.found_name    = name_r;
  assign out_ch.found_ext     = ext_r;

`ifndef SYNTHESIS
  a_result_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_valid |=> search_done_r)
    else $error("result issued without closing the search");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_first_r |=> valid_count_r >= $past(valid_count_r))
    else $error("valid entry count went down within a search");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == ST_FOUND || status_r == ST_END ||
                     status_r == ST_EXHAUSTED))
    else $error("illegal status code on output");

  a_miss_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_FOUND |->
      cluster_r == '0 && size_r == '0 && !is_dir_r && name_r == '0 && ext_r == '0)
    else $error("non-found result carries entry data");

  a_done_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && search_done_r && !s1_first_r |=> !out_valid_r)
    else $error("result issued after search completed");
`endif

endmodule

[test/fat16_root_directory_search_top_tb.sv]
// Self-checking testbench for the FAT16 root directory search block.
module fat16_root_directory_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import f16rds_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int TAIL_CYCLES = 8;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic                 first_entry;
    logic                 last_entry;
    logic [NAME_W-1:0]    name;
    logic [EXT_W-1:0]     ext;
    logic [ATTR_W-1:0]    attr;
    logic [CLUSTER_W-1:0] cluster;
    logic [SIZE_W-1:0]    size;
  } dir_entry_t;

  typedef struct packed {
    status_t              status;
    logic [CLUSTER_W-1:0] cluster;
    logic [SIZE_W-1:0]    size;
    logic                 is_dir;
    logic [NAME_W-1:0]    name;
    logic [EXT_W-1:0]     ext;
  } search_result_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    cfg_reg_t             reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    dir_entry_t           ent;
    search_result_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  f16rds_in_if  in_ch ();
  f16rds_out_if out_ch ();

  fat16_root_directory_search_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic                 mode_sel;
  logic [NAME_W-1:0]    want_name;
  logic [EXT_W-1:0]     want_ext;
  logic [COUNT_W-1:0]   want_pos;
  logic [COUNT_W-1:0]   seen_valid;
  logic                 lookup_done;

  search_result_t pending_results[$];
  stim_row_t      plan[$];

  bit quiet_in;
  bit quiet_out;
  bit hold_req;
  int mismatches;
  int items_sent;
  int words_checked;
  int dirs_walked;
  int idle_cycles;

  function automatic bit predict_lookup(input dir_entry_t ent, output search_result_t res);
    logic [7:0] lead;
    bit usable;
    bit hit;
    res = '0;
    lead = ent.name[NAME_W-1 -: 8];
    if (ent.first_entry) begin
      seen_valid = '0;
      lookup_done = 1'b0;
    end
    if (lookup_done) return 1'b0;
    if (lead == LEAD_END) begin
      lookup_done = 1'b1;
      res.status = ST_END;
      return 1'b1;
    end
    usable = !(lead == LEAD_DELETED || ent.attr == ATTR_LFN || (ent.attr & ATTR_VOLUME) != 0);
    if (usable) begin
      if (mode_sel) hit = (seen_valid == want_pos);
      else hit = (ent.name == want_name) && (ent.ext == want_ext);
      if (hit) begin
        lookup_done = 1'b1;
        res.status = ST_FOUND;
        res.cluster = ent.cluster;
        res.size = ent.size;
        res.is_dir = (ent.attr & ATTR_DIR) != 0;
        res.name = ent.name;
        res.ext = ent.ext;
        return 1'b1;
      end
      if (seen_valid != COUNT_MAX) seen_valid = seen_valid + 1'b1;
    end
    if (ent.last_entry) begin
      lookup_done = 1'b1;
      res.status = ST_EXHAUSTED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic search_result_t mk_result(input status_t st, input logic [15:0] cl,
                                               input logic [31:0] sz, input logic dir,
                                               input logic [63:0] nm, input logic [23:0] ex);
    search_result_t r;
    r.status = st;
    r.cluster = cl;
    r.size = sz;
    r.is_dir = dir;
    r.name = nm;
    r.ext = ex;
    return r;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic fe, input logic le,
                                  input logic [63:0] nm, input logic [23:0] ex,
                                  input logic [7:0] at, input logic [15:0] cl,
                                  input logic [31:0] sz, input search_result_t res);
    stim_row_t row;
    row.kind = kind;
    row.reg_idx = CFG_SEARCH_MODE;
    row.reg_data = '0;
    row.ent = {fe, le, nm, ex, at, cl, sz};
    row.res = res;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_reg_t idx, input logic [63:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_data = data;
    row.ent = '0;
    row.res = '0;
    plan.push_back(row);
  endfunction

  function automatic void build_plan();
    search_result_t none;
    search_result_t gone;
    none = '0;
    gone = mk_result(ST_EXHAUSTED, '0, '0, 1'b0, '0, '0);
    add_row(ROW_TYPED, 1'b1, 1'b0, 64'h0, 24'h0, 8'h00, 16'h0, 32'h0,
            mk_result(ST_END, '0, '0, 1'b0, '0, '0));
    add_row(ROW_TYPED, 1'b1, 1'b0, NAME_RESET, EXT_RESET, ATTR_DIR, 16'hFFFF, 32'hFFFF_FFFF,
            mk_result(ST_FOUND, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, NAME_RESET, EXT_RESET));
    add_row(ROW_PREDICT, 1'b1, 1'b0, 64'hE520_2020_2020_2020, EXT_RESET, 8'h00, 16'h1, 32'h1,
            none);
    add_row(ROW_PREDICT, 1'b0, 1'b0, NAME_RESET, EXT_RESET, ATTR_LFN, 16'h2, 32'h2, none);
    add_row(ROW_TYPED, 1'b0, 1'b1, NAME_RESET, EXT_RESET, ATTR_VOLUME, 16'h3, 32'h3, gone);
    add_row(ROW_PREDICT, 1'b1, 1'b0, '1, '1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, none);
    add_row(ROW_TYPED, 1'b0, 1'b1, '1, '1, 8'hF7, 16'hFFFF, 32'hFFFF_FFFF, gone);
    add_row(ROW_TYPED, 1'b1, 1'b1, 64'h00FF_FFFF_FFFF_FFFF, '1, 8'hFF, 16'hFFFF,
            32'hFFFF_FFFF, mk_result(ST_END, '0, '0, 1'b0, '0, '0));
    add_row(ROW_PREDICT, 1'b0, 1'b1, NAME_RESET, EXT_RESET, 8'h00, 16'h4, 32'h4, none);
    add_row(ROW_TYPED, 1'b1, 1'b1, NAME_RESET, EXT_RESET, 8'h00, 16'h0, 32'h0,
            mk_result(ST_FOUND, '0, '0, 1'b0, NAME_RESET, EXT_RESET));
    add_cfg(CFG_SEARCH_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    add_cfg(CFG_TARGET_NAME, 64'h4B45_524E_454C_2020);
    add_cfg(CFG_TARGET_EXT, 64'h53_5953);
    add_row(ROW_PREDICT, 1'b1, 1'b0, 64'h4B45_524E_454C_2020, 24'h53_5958, 8'h20, 16'h2,
            32'h1000, none);
    add_row(ROW_PREDICT, 1'b0, 1'b0, 64'h4B45_524E_454C_2020, 24'h53_5953, 8'h21, 16'h1234,
            32'h0001_2345, none);
    add_cfg(CFG_SEARCH_MODE, 64'h3);
    add_cfg(CFG_TARGET_INDEX, 64'h2);
    add_row(ROW_PREDICT, 1'b1, 1'b0, 64'h4141_4141_2020_2020, EXT_RESET, 8'h10, 16'h10, 32'h0,
            none);
    add_row(ROW_PREDICT, 1'b0, 1'b0, 64'hE542_4242_2020_2020, EXT_RESET, 8'h00, 16'h11, 32'h5,
            none);
    add_row(ROW_PREDICT, 1'b0, 1'b0, 64'h4243_4400_FFFF_FFFF, 24'hFF_FFFF, ATTR_LFN, 16'h0,
            32'h0, none);
    add_row(ROW_PREDICT, 1'b0, 1'b0, 64'h4242_4242_2020_2020, 24'h54_5854, 8'h01, 16'h12,
            32'h7, none);
    add_row(ROW_PREDICT, 1'b0, 1'b0, 64'h4343_4343_2020_2020, 24'h42_494E, 8'h30, 16'h13,
            32'h9, none);
    add_row(ROW_PREDICT, 1'b1, 1'b1, 64'h4444_2020_2020_2020, EXT_RESET, 8'h00, 16'h14, 32'hA,
            none);
    add_cfg(CFG_TARGET_INDEX, 64'h0);
    add_row(ROW_PREDICT, 1'b1, 1'b0, 64'h4545_2020_2020_2020, EXT_RESET, 8'h10, 16'h15, 32'hB,
            none);
  endfunction

  function automatic logic [7:0] live_lead();
    logic [7:0] lead;
    do lead = 8'($urandom); while (lead == LEAD_END || lead == LEAD_DELETED);
    return lead;
  endfunction

  function automatic dir_entry_t make_valid_entry();
    dir_entry_t ent;
    ent.first_entry = 1'b0;
    ent.last_entry = 1'b0;
    ent.name = {live_lead(), 56'({$urandom, $urandom})};
    ent.ext = 24'($urandom);
    ent.attr = 8'($urandom) & ~ATTR_VOLUME;
    ent.cluster = 16'($urandom);
    ent.size = $urandom;
    return ent;
  endfunction

  function automatic dir_entry_t make_entry(output bit noisy);
    dir_entry_t ent;
    int pick;
    noisy = 1'b0;
    ent = make_valid_entry();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
    end else if (pick < 60) begin
      ent.name = want_name;
      ent.ext = want_ext;
    end else if (pick < 70) begin
      ent.name[63:56] = LEAD_DELETED;
      ent.attr = 8'($urandom);
    end else if (pick < 78) begin
      ent.attr = ATTR_LFN;
    end else if (pick < 86) begin
      ent.attr = 8'($urandom) | ATTR_VOLUME;
    end else if (pick < 90) begin
      ent.name[63:56] = LEAD_END;
      ent.attr = 8'($urandom);
    end else begin
      noisy = 1'b1;
      ent.name = {$urandom, $urandom};
      ent.attr = 8'($urandom);
      ent.first_entry = 1'($urandom);
      ent.last_entry = 1'($urandom);
    end
    return ent;
  endfunction

  task automatic send_entry(input dir_entry_t ent, input bit typed,
                            input search_result_t typed_res);
    int gap;
    bit produced;
    search_result_t res;
    gap = quiet_in ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.first_entry = ent.first_entry;
    in_ch.last_entry = ent.last_entry;
    in_ch.entry_name = ent.name;
    in_ch.entry_ext = ent.ext;
    in_ch.entry_attr = ent.attr;
    in_ch.entry_cluster = ent.cluster;
    in_ch.entry_size = ent.size;
    do @(posedge clk); while (!in_ch.ready);
    produced = predict_lookup(ent, res);
    if (typed) pending_results.push_back(typed_res);
    else if (produced) pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      CFG_SEARCH_MODE:  mode_sel = data[0];
      CFG_TARGET_NAME:  want_name = data;
      CFG_TARGET_EXT:   want_ext = data[EXT_W-1:0];
      CFG_TARGET_INDEX: want_pos = data[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic randomize_targets();
    logic [63:0] nm;
    logic [23:0] ex;
    logic [15:0] pos;
    case ($urandom_range(0, 5))
      0: begin
        nm = '0;
        ex = '0;
      end
      1: begin
        nm = '1;
        ex = '1;
      end
      2: begin
        nm = NAME_RESET;
        ex = EXT_RESET;
      end
      default: begin
        nm = {live_lead(), 56'({$urandom, $urandom})};
        ex = 24'($urandom);
      end
    endcase
    case ($urandom_range(0, 4))
      0: pos = '0;
      1: pos = COUNT_MAX;
      default: pos = 16'($urandom_range(0, 12));
    endcase
    write_reg(CFG_SEARCH_MODE, {$urandom, $urandom});
    write_reg(CFG_TARGET_NAME, nm);
    write_reg(CFG_TARGET_EXT, {40'($urandom), ex});
    write_reg(CFG_TARGET_INDEX, {48'({$urandom, $urandom}), pos});
  endtask

  task automatic run_directories(input int n_items);
    int count;
    int len;
    bit noisy;
    dir_entry_t ent;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      dirs_walked++;
      for (int k = 0; k < len; k++) begin
        ent = make_entry(noisy);
        if (!noisy) begin
          ent.first_entry = (k == 0);
          ent.last_entry = (k == len - 1);
        end
        send_entry(ent, 1'b0, '0);
        count++;
      end
    end
  endtask

  task automatic squeeze_output();
    dir_entry_t ent;
    settle();
    hold_req = 1'b1;
    quiet_in = 1'b1;
    for (int k = 0; k < 16; k++) begin
      ent = make_valid_entry();
      ent.first_entry = 1'b1;
      ent.name[63:56] = LEAD_END;
      send_entry(ent, 1'b0, '0);
    end
    settle();
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        $error("status: expected no word, got %0d", out_ch.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("found_cluster", want.cluster, out_ch.found_cluster);
        check_field("found_size", want.size, out_ch.found_size);
        check_field("is_directory", want.is_dir, out_ch.is_directory);
        check_field("found_name", want.name, out_ch.found_name);
        check_field("found_ext", want.ext, out_ch.found_ext);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_results.size());
      $display("fat16_root_directory_search_top_tb failed");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = quiet_out ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SEARCH_MODE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.first_entry = 1'b0;
    in_ch.last_entry = 1'b0;
    in_ch.entry_name = '0;
    in_ch.entry_ext = '0;
    in_ch.entry_attr = '0;
    in_ch.entry_cluster = '0;
    in_ch.entry_size = '0;
    mode_sel = 1'b0;
    want_name = NAME_RESET;
    want_ext = EXT_RESET;
    want_pos = '0;
    seen_valid = '0;
    lookup_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    build_plan();
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[i].reg_idx, plan[i].reg_data);
        end
        ROW_TYPED: send_entry(plan[i].ent, 1'b1, plan[i].res);
        default:   send_entry(plan[i].ent, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      randomize_targets();
      if (ph == 3) squeeze_output();
      run_directories(225);
    end
    quiet_out = 1'b0;
    settle();

    $display("sent %0d entries (%0d random directory walks), checked %0d result words",
             items_sent, dirs_walked, words_checked);
    $display("covered directed edge rows, name and index searches and a long output hold-off");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("fat16_root_directory_search_top_tb passed");
    end else begin
      $display("fat16_root_directory_search_top_tb failed");
    end
    $finish;
  end

endmodule
